>>> rtl/core/gsa_pkg.sv
package gsa_pkg;

    localparam int IDX_W = 5;
    localparam int CNT_W = 6;

    localparam logic [2:0] ACT_ALLOCATE = 3'd0;
    localparam logic [2:0] ACT_RETIRE   = 3'd1;
    localparam logic [2:0] ACT_COLLECT  = 3'd2;
    localparam logic [2:0] ACT_IS_ACT   = 3'd3;
    localparam logic [2:0] ACT_REQUIRE  = 3'd4;
    localparam logic [2:0] ACT_RESV     = 3'd5;
    localparam logic [2:0] ACT_DRAIN    = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_FOREIGN   = 3'd2;
    localparam logic [2:0] ST_STALE     = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd5;
    localparam logic [2:0] ST_RETIRED   = 3'd6;
    localparam logic [2:0] ST_RESERVED  = 3'd7;

    localparam logic [7:0] REG_TABLE_TAG = 8'd0;
    localparam logic [7:0] REG_RESERVED  = 8'd1;

    typedef enum logic [1:0] {
        KIND_FREE     = 2'd0,
        KIND_RESERVED = 2'd1,
        KIND_ACTIVE   = 2'd2,
        KIND_RETIRED  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_COUNT,
        FSM_COLLECT,
        FSM_DRAIN
    } fsm_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  handle_index;
        logic [31:0] handle_generation;
        logic [15:0] handle_tag;
        logic [63:0] fence_value;
    } in_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             item_valid;
        logic [IDX_W-1:0] slot_index;
        logic [31:0]      slot_generation;
        logic             is_active_flag;
        logic             last_of_run;
        logic [CNT_W-1:0] in_use_count;
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] retiring_count;
        logic [CNT_W-1:0] peak_in_use;
        logic [CNT_W-1:0] dirty_count;
    } out_t;

    typedef struct packed {
        logic [31:0] gen;
        logic [15:0] tag;
        logic        in_range;
        logic [31:0] slot_gen;
        logic [15:0] table_tag;
    } chk_req_t;

endpackage

>>> rtl/core/gsa_check.sv
// handle validation: zero generation, foreign tag, range, stale generation
module gsa_check (
    input  gsa_pkg::chk_req_t req,
    output logic [2:0]        status
);
    always_comb begin
        if (req.gen == 32'd0) begin
            status = gsa_pkg::ST_INVALID;
        end else if (req.tag != req.table_tag) begin
            status = gsa_pkg::ST_FOREIGN;
        end else if (!req.in_range) begin
            status = gsa_pkg::ST_INVALID;
        end else if (req.gen != req.slot_gen) begin
            status = gsa_pkg::ST_STALE;
        end else begin
            status = gsa_pkg::ST_OK;
        end
    end
endmodule

>>> rtl/core/generational_slot_allocator.sv
// generational slot allocator: a table of CAPACITY slots with 32-bit generations, a lifo
// free stack and a fenced retirement queue. one word in, one or more words out; every
// output word carries the usage counters as they stand after the whole action. allocate,
// retire, the active queries and reserved lookup pass through a capture and an execute state.
// collect walks the retirement queue twice through a single 64-bit fence comparator,
// once to count the slots due and once to free and compact.
// drain_dirty steps one slot a cycle over the table. an output word
// that is not taken stalls the walk. writing reserved_count reinitialises the table;
// reset does the same with no reserved slots.
module generational_slot_allocator #(
    parameter int CAPACITY = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  gsa_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output gsa_pkg::out_t  m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_index,
    input  logic [15:0]    cfg_data
);
    localparam int IW = gsa_pkg::IDX_W;
    localparam int CW = gsa_pkg::CNT_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    // slot table and queues
    gsa_pkg::kind_t slot_kind_reg [CAPACITY];
    logic [31:0]    slot_gen_reg  [CAPACITY];
    logic           dirty_reg     [CAPACITY];
    logic [IW-1:0]  stack_reg     [CAPACITY];
    logic [IW-1:0]  rq_slot_reg   [CAPACITY];
    logic [63:0]    rq_fence_reg  [CAPACITY];

    logic [CW-1:0] free_depth_reg, free_depth_next;
    logic [CW-1:0] retire_depth_reg, retire_depth_next;
    logic [CW-1:0] use_now_reg, use_now_next;
    logic [CW-1:0] use_peak_reg, use_peak_next;
    logic [CW-1:0] dirty_total_reg, dirty_total_next;
    logic [15:0]   table_tag_reg;

    // sequencer
    gsa_pkg::fsm_t state_reg, state_next;
    gsa_pkg::in_t  cmd_reg, cmd_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] keep_reg, keep_next;
    logic [CW-1:0] due_reg, due_next;
    logic [CW-1:0] nd_reg, nd_next;
    logic [CW-1:0] emit_reg, emit_next;
    logic [CW-1:0] fin_free_reg, fin_free_next;
    logic [CW-1:0] fin_ret_reg, fin_ret_next;
    logic [CW-1:0] fin_dirty_reg, fin_dirty_next;

    // output register
    gsa_pkg::out_t out_reg, out_d;
    logic          out_valid_reg, out_load;

    // write strobes
    logic           kind_we, gen_we, dset_we, dclr_we, stk_we, rq_we;
    logic [IW-1:0]  kind_wa, gen_wa, dset_wa, dclr_wa, stk_wa, rq_wa;
    gsa_pkg::kind_t kind_wd;
    logic [31:0]    gen_wd;
    logic [IW-1:0]  stk_wd, rq_slot_wd;
    logic [63:0]    rq_fence_wd;

    // table reinitialisation
    logic          init;
    logic [CW-1:0] init_r;
    logic [CW-1:0] cfg_r;

    // read side
    logic           in_rng;
    logic [IW-1:0]  ia;
    gsa_pkg::kind_t kind_at;
    logic [31:0]    gen_at;
    logic [CW-1:0]  top_p;
    logic [IW-1:0]  top_slot;
    logic [IW-1:0]  qp;
    logic           q_ok;
    logic [IW-1:0]  q_slot;
    logic [63:0]    q_fence;
    logic           q_due;
    logic [31:0]    gen_q, gen_inc;
    logic           dirty_q;
    logic           dirty_p;
    logic [31:0]    gen_p;
    logic           can_load;
    gsa_pkg::chk_req_t chk_req;
    logic [2:0]     chk_status;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == gsa_pkg::FSM_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign can_load  = !out_valid_reg || m_ready;

    assign cfg_r  = (cfg_data[CW-1:0] > CAP) ? CAP : cfg_data[CW-1:0];
    assign init   = !aresetn || (cfg_valid && cfg_index == gsa_pkg::REG_RESERVED);
    assign init_r = !aresetn ? '0 : cfg_r;

    // presented handle
    assign in_rng  = (cmd_reg.handle_index < 8'(CAPACITY));
    assign ia      = cmd_reg.handle_index[IW-1:0];
    assign kind_at = in_rng ? slot_kind_reg[ia] : gsa_pkg::KIND_FREE;
    assign gen_at  = in_rng ? slot_gen_reg[ia] : '0;

    // top of free stack
    assign top_p    = free_depth_reg - CW'(1);
    assign top_slot = (free_depth_reg != '0) ? stack_reg[top_p[IW-1:0]] : '0;

    // queue entry under the walk pointer
    assign qp      = ptr_reg[IW-1:0];
    assign q_ok    = (ptr_reg < CAP);
    assign q_slot  = q_ok ? rq_slot_reg[qp] : '0;
    assign q_fence = q_ok ? rq_fence_reg[qp] : '0;
    assign q_due   = (q_fence <= cmd_reg.fence_value);
    assign gen_q   = slot_gen_reg[q_slot];
    assign dirty_q = dirty_reg[q_slot];
    assign gen_inc = (gen_q + 32'd1 == 32'd0) ? 32'd1 : gen_q + 32'd1;

    // slot under the drain pointer
    assign dirty_p = q_ok ? dirty_reg[qp] : 1'b0;
    assign gen_p   = q_ok ? slot_gen_reg[qp] : '0;

    assign chk_req = '{gen: cmd_reg.handle_generation, tag: cmd_reg.handle_tag,
                       in_range: in_rng, slot_gen: gen_at, table_tag: table_tag_reg};

    gsa_check u_check (
        .req    (chk_req),
        .status (chk_status)
    );

    always_comb begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        ptr_next          = ptr_reg;
        keep_next         = keep_reg;
        due_next          = due_reg;
        nd_next           = nd_reg;
        emit_next         = emit_reg;
        fin_free_next     = fin_free_reg;
        fin_ret_next      = fin_ret_reg;
        fin_dirty_next    = fin_dirty_reg;
        free_depth_next   = free_depth_reg;
        retire_depth_next = retire_depth_reg;
        use_now_next      = use_now_reg;
        use_peak_next     = use_peak_reg;
        dirty_total_next  = dirty_total_reg;
        kind_we = 1'b0; kind_wa = '0; kind_wd = gsa_pkg::KIND_FREE;
        gen_we  = 1'b0; gen_wa  = '0; gen_wd  = '0;
        dset_we = 1'b0; dset_wa = '0;
        dclr_we = 1'b0; dclr_wa = '0;
        stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0;
        rq_we   = 1'b0; rq_wa   = '0; rq_slot_wd = '0; rq_fence_wd = '0;
        out_load = 1'b0;
        out_d    = '0;
        case (state_reg)
            gsa_pkg::FSM_IDLE: begin
                if (s_valid) begin
                    cmd_next  = s_data;
                    ptr_next  = '0;
                    keep_next = '0;
                    due_next  = '0;
                    nd_next   = '0;
                    emit_next = '0;
                    if (s_data.action == gsa_pkg::ACT_COLLECT) begin
                        state_next = gsa_pkg::FSM_COUNT;
                    end else if (s_data.action == gsa_pkg::ACT_DRAIN) begin
                        due_next   = dirty_total_reg;
                        state_next = gsa_pkg::FSM_DRAIN;
                    end else begin
                        state_next = gsa_pkg::FSM_EXEC;
                    end
                end
            end
            gsa_pkg::FSM_EXEC: begin
                if (can_load) begin
                    out_load = 1'b1;
                    out_d.last_of_run = 1'b1;
                    state_next = gsa_pkg::FSM_IDLE;
                    case (cmd_reg.action)
                        gsa_pkg::ACT_ALLOCATE: begin
                            if (free_depth_reg == '0) begin
                                out_d.status = gsa_pkg::ST_EXHAUSTED;
                            end else begin
                                free_depth_next = top_p;
                                kind_we = 1'b1; kind_wa = top_slot;
                                kind_wd = gsa_pkg::KIND_ACTIVE;
                                use_now_next = use_now_reg + CW'(1);
                                if (use_now_next > use_peak_reg) begin
                                    use_peak_next = use_now_next;
                                end
                                if (!dirty_reg[top_slot]) begin
                                    dset_we = 1'b1; dset_wa = top_slot;
                                    dirty_total_next = dirty_total_reg + CW'(1);
                                end
                                out_d.item_valid      = 1'b1;
                                out_d.slot_index      = top_slot;
                                out_d.slot_generation = slot_gen_reg[top_slot];
                            end
                        end
                        gsa_pkg::ACT_RETIRE: begin
                            out_d.status = chk_status;
                            if (chk_status == gsa_pkg::ST_OK) begin
                                case (kind_at)
                                    gsa_pkg::KIND_RESERVED: out_d.status = gsa_pkg::ST_RESERVED;
                                    gsa_pkg::KIND_FREE:     out_d.status = gsa_pkg::ST_NOT_ALLOC;
                                    gsa_pkg::KIND_RETIRED:  out_d.status = gsa_pkg::ST_RETIRED;
                                    default:                out_d.status = gsa_pkg::ST_OK;
                                endcase
                            end
                            if (out_d.status == gsa_pkg::ST_OK && retire_depth_reg < CAP) begin
                                kind_we = 1'b1; kind_wa = ia;
                                kind_wd = gsa_pkg::KIND_RETIRED;
                                rq_we = 1'b1; rq_wa = retire_depth_reg[IW-1:0];
                                rq_slot_wd  = ia;
                                rq_fence_wd = cmd_reg.fence_value;
                                retire_depth_next = retire_depth_reg + CW'(1);
                                use_now_next = use_now_reg - CW'(1);
                            end
                        end
                        gsa_pkg::ACT_IS_ACT: begin
                            out_d.is_active_flag = (chk_status == gsa_pkg::ST_OK) &&
                                (kind_at == gsa_pkg::KIND_ACTIVE ||
                                 kind_at == gsa_pkg::KIND_RESERVED);
                        end
                        gsa_pkg::ACT_REQUIRE: begin
                            out_d.status = chk_status;
                            if (chk_status == gsa_pkg::ST_OK) begin
                                if (kind_at == gsa_pkg::KIND_FREE) begin
                                    out_d.status = gsa_pkg::ST_NOT_ALLOC;
                                end else if (kind_at == gsa_pkg::KIND_RETIRED) begin
                                    out_d.status = gsa_pkg::ST_RETIRED;
                                end
                            end
                        end
                        gsa_pkg::ACT_RESV: begin
                            if (!in_rng || kind_at != gsa_pkg::KIND_RESERVED) begin
                                out_d.status = gsa_pkg::ST_INVALID;
                            end else begin
                                out_d.item_valid      = 1'b1;
                                out_d.slot_index      = ia;
                                out_d.slot_generation = gen_at;
                            end
                        end
                        default: begin
                            out_d.status = gsa_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            gsa_pkg::FSM_COUNT: begin
                // first pass: how many entries are due and how many are new dirty marks
                if (ptr_reg == retire_depth_reg) begin
                    fin_free_next  = free_depth_reg + due_reg;
                    fin_ret_next   = retire_depth_reg - due_reg;
                    fin_dirty_next = dirty_total_reg + nd_reg;
                    ptr_next   = '0;
                    state_next = gsa_pkg::FSM_COLLECT;
                end else begin
                    if (q_due) begin
                        due_next = due_reg + CW'(1);
                        if (!dirty_q) begin
                            nd_next = nd_reg + CW'(1);
                        end
                    end
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            gsa_pkg::FSM_COLLECT: begin
                // second pass: free due entries in order, compact the rest
                if (ptr_reg == retire_depth_reg) begin
                    if (due_reg == '0) begin
                        if (can_load) begin
                            out_load = 1'b1;
                            out_d.last_of_run = 1'b1;
                            state_next = gsa_pkg::FSM_IDLE;
                        end
                    end else begin
                        retire_depth_next = keep_reg;
                        state_next = gsa_pkg::FSM_IDLE;
                    end
                end else if (!q_due) begin
                    rq_we = 1'b1; rq_wa = keep_reg[IW-1:0];
                    rq_slot_wd = q_slot; rq_fence_wd = q_fence;
                    keep_next = keep_reg + CW'(1);
                    ptr_next  = ptr_reg + CW'(1);
                end else if (can_load) begin
                    out_load = 1'b1;
                    out_d.item_valid      = 1'b1;
                    out_d.slot_index      = q_slot;
                    out_d.slot_generation = gen_q;
                    out_d.last_of_run     = (emit_reg + CW'(1) == due_reg);
                    gen_we = 1'b1; gen_wa = q_slot; gen_wd = gen_inc;
                    kind_we = 1'b1; kind_wa = q_slot; kind_wd = gsa_pkg::KIND_FREE;
                    if (free_depth_reg < CAP) begin
                        stk_we = 1'b1; stk_wa = free_depth_reg[IW-1:0]; stk_wd = q_slot;
                        free_depth_next = free_depth_reg + CW'(1);
                    end
                    if (!dirty_q) begin
                        dset_we = 1'b1; dset_wa = q_slot;
                        dirty_total_next = dirty_total_reg + CW'(1);
                    end
                    emit_next = emit_reg + CW'(1);
                    ptr_next  = ptr_reg + CW'(1);
                end
            end
            gsa_pkg::FSM_DRAIN: begin
                if (ptr_reg == CAP) begin
                    if (due_reg == '0) begin
                        if (can_load) begin
                            out_load = 1'b1;
                            out_d.last_of_run = 1'b1;
                            dirty_total_next = '0;
                            state_next = gsa_pkg::FSM_IDLE;
                        end
                    end else begin
                        dirty_total_next = '0;
                        state_next = gsa_pkg::FSM_IDLE;
                    end
                end else if (!dirty_p) begin
                    ptr_next = ptr_reg + CW'(1);
                end else if (can_load) begin
                    out_load = 1'b1;
                    out_d.item_valid      = 1'b1;
                    out_d.slot_index      = qp;
                    out_d.slot_generation = gen_p;
                    out_d.last_of_run     = (emit_reg + CW'(1) == due_reg);
                    dclr_we = 1'b1; dclr_wa = qp;
                    emit_next = emit_reg + CW'(1);
                    ptr_next  = ptr_reg + CW'(1);
                end
            end
            default: begin
                state_next = gsa_pkg::FSM_IDLE;
            end
        endcase

        // counters as they stand after the whole action
        case (state_reg)
            gsa_pkg::FSM_COLLECT: begin
                out_d.in_use_count   = use_now_reg;
                out_d.free_count     = fin_free_reg;
                out_d.retiring_count = fin_ret_reg;
                out_d.peak_in_use    = use_peak_reg;
                out_d.dirty_count    = fin_dirty_reg;
            end
            gsa_pkg::FSM_DRAIN: begin
                out_d.in_use_count   = use_now_reg;
                out_d.free_count     = free_depth_reg;
                out_d.retiring_count = retire_depth_reg;
                out_d.peak_in_use    = use_peak_reg;
                out_d.dirty_count    = '0;
            end
            default: begin
                out_d.in_use_count   = use_now_next;
                out_d.free_count     = free_depth_next;
                out_d.retiring_count = retire_depth_next;
                out_d.peak_in_use    = use_peak_next;
                out_d.dirty_count    = dirty_total_next;
            end
        endcase
    end

    // slot table, queues and counters
    always_ff @(posedge aclk) begin
        if (init) begin
            for (int i = 0; i < CAPACITY; i++) begin
                slot_kind_reg[i] <= (i < int'(init_r)) ? gsa_pkg::KIND_RESERVED
                                                       : gsa_pkg::KIND_FREE;
                slot_gen_reg[i]  <= 32'd1;
                dirty_reg[i]     <= (i < int'(init_r));
                stack_reg[i]     <= (i < CAPACITY - int'(init_r)) ? IW'(CAPACITY - 1 - i) : '0;
            end
            free_depth_reg   <= CAP - init_r;
            retire_depth_reg <= '0;
            use_now_reg      <= init_r;
            use_peak_reg     <= init_r;
            dirty_total_reg  <= init_r;
        end else begin
            if (kind_we) begin
                slot_kind_reg[kind_wa] <= kind_wd;
            end
            if (gen_we) begin
                slot_gen_reg[gen_wa] <= gen_wd;
            end
            if (dset_we) begin
                dirty_reg[dset_wa] <= 1'b1;
            end
            if (dclr_we) begin
                dirty_reg[dclr_wa] <= 1'b0;
            end
            if (stk_we) begin
                stack_reg[stk_wa] <= stk_wd;
            end
            free_depth_reg   <= free_depth_next;
            retire_depth_reg <= retire_depth_next;
            use_now_reg      <= use_now_next;
            use_peak_reg     <= use_peak_next;
            dirty_total_reg  <= dirty_total_next;
        end
        if (rq_we) begin
            rq_slot_reg[rq_wa]  <= rq_slot_wd;
            rq_fence_reg[rq_wa] <= rq_fence_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_tag_reg <= 16'd1;
        end else if (cfg_valid && cfg_index == gsa_pkg::REG_TABLE_TAG) begin
            table_tag_reg <= cfg_data;
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gsa_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cmd_reg       <= cmd_next;
        ptr_reg       <= ptr_next;
        keep_reg      <= keep_next;
        due_reg       <= due_next;
        nd_reg        <= nd_next;
        emit_reg      <= emit_next;
        fin_free_reg  <= fin_free_next;
        fin_ret_reg   <= fin_ret_next;
        fin_dirty_reg <= fin_dirty_next;
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) begin
            out_reg <= out_d;
        end
    end
endmodule
